### src/tcbd_pkg.sv
`timescale 1ns / 1ps

package tcbd_pkg;

   localparam int DIST_W      = 8;
   localparam int MAXD_W      = 8;
   localparam int IMG_WIDTH_W = 11;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [MAXD_W-1:0]      MAXD_RESET      = 8'd0;
   localparam logic [IMG_WIDTH_W-1:0] IMG_WIDTH_RESET = 11'd1024;

   typedef enum logic [0:0] {
      CSR_MAX_DISTANCE = 1'b0,
      CSR_IMAGE_WIDTH  = 1'b1
   } csr_reg_type;

endpackage

### src/tcbd_if.sv
`timescale 1ns / 1ps

interface tcbd_req_if;
   logic valid;
   logic ready;
   logic pixel;
   logic image_start;

   modport source (output valid, output pixel, output image_start, input ready);
   modport sink   (input valid, input pixel, input image_start, output ready);
endinterface

interface tcbd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tcbd_pkg::DIST_W-1:0] distance;
   logic                        row_end;

   modport source (output valid, output distance, output row_end, input ready);
   modport sink   (input valid, input distance, input row_end, output ready);
endinterface

### src/tcbd_ram.sv
`timescale 1ns / 1ps

module tcbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 3072
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

### src/translated_city_block_distance_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake     Payload
// req_chan  in   valid/ready   pixel, image_start
// rsp_chan  out  valid/ready   distance, row_end
// csr_*     in   APB write     max_distance (0x0), image_width (0x4)
//
// One pixel per clock while not stalled; middle stage, then response register.
// Rate is set by the line store: two reads and one write per pixel in one RAM.
// Synchronous reset clears row position and pipeline; line store is not cleared.
// A stalled response holds the middle stage; requests resume when it drains.

module translated_city_block_distance_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int VALUE_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   tcbd_req_if.sink                            req_chan,
   tcbd_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tcbd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tcbd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tcbd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int IW    = $clog2(MAX_WIDTH);
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int DEPTH = 3 * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int VB    = VALUE_BITS;

   localparam logic [VB-1:0] ValueMask = {VB{1'b1}};
   localparam logic [AW-1:0] Base1     = AW'(MAX_WIDTH);
   localparam logic [AW-1:0] Base2     = AW'(2 * MAX_WIDTH);

   function automatic logic [AW-1:0] slot_base(input logic [1:0] slot);
      logic [AW-1:0] b;
      b = '0;
      if (slot == 2'd1) begin
         b = Base1;
      end else if (slot == 2'd2) begin
         b = Base2;
      end
      return b;
   endfunction

   // configuration
   logic [tcbd_pkg::MAXD_W-1:0]      max_ff;
   logic [tcbd_pkg::IMG_WIDTH_W-1:0] width_ff;
   logic                             csr_wr;
   tcbd_pkg::csr_reg_type            csr_sel;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = tcbd_pkg::csr_reg_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= tcbd_pkg::MAXD_RESET;
         width_ff <= tcbd_pkg::IMG_WIDTH_RESET;
      end else if (csr_wr) begin
         unique case (csr_sel)
            tcbd_pkg::CSR_MAX_DISTANCE: max_ff   <= csr_pwdata[tcbd_pkg::MAXD_W-1:0];
            tcbd_pkg::CSR_IMAGE_WIDTH:  width_ff <= csr_pwdata[tcbd_pkg::IMG_WIDTH_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         tcbd_pkg::CSR_MAX_DISTANCE: csr_prdata = tcbd_pkg::CSR_DATA_W'(max_ff);
         tcbd_pkg::CSR_IMAGE_WIDTH:  csr_prdata = tcbd_pkg::CSR_DATA_W'(width_ff);
      endcase
   end

   logic [CW-1:0] width_w;
   logic [VB-1:0] dmax_w;
   logic [VB-1:0] cap_w;

   always_comb begin
      if (width_ff == '0) begin
         width_w = CW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         width_w = CW'(MAX_WIDTH);
      end else begin
         width_w = CW'(width_ff);
      end
      if (max_ff == '0 || 32'(max_ff) > 32'(ValueMask)) begin
         dmax_w = ValueMask;
      end else begin
         dmax_w = VB'(max_ff);
      end
      cap_w = dmax_w - VB'(1);
   end

   // row position, request stage
   logic [IW-1:0] col_ff, col_in;
   logic [1:0]    rows_ff, rows_in;
   logic [1:0]    slot_ff, slot_in;
   logic [IW-1:0] col_now;
   logic [IW-1:0] col_inc;
   logic [1:0]    rows_now;
   logic          last_now;
   logic [1:0]    up_slot;
   logic [1:0]    up2_slot;
   logic [AW-1:0] rd_addr_up;
   logic [AW-1:0] rd_addr_up2;
   logic          req_fire;

   logic          s1_valid_ff;
   logic          s1_adv;
   logic          rsp_valid_ff;

   assign s1_adv         = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      col_now  = req_chan.image_start ? '0 : col_ff;
      rows_now = req_chan.image_start ? 2'd0 : rows_ff;
      col_inc  = col_now + IW'(1);
      last_now = (CW'(col_now) + CW'(1)) >= width_w;

      unique case (slot_ff)
         2'd0:    begin up_slot = 2'd2; up2_slot = 2'd1; end
         2'd1:    begin up_slot = 2'd0; up2_slot = 2'd2; end
         default: begin up_slot = 2'd1; up2_slot = 2'd0; end
      endcase

      rd_addr_up  = slot_base(up_slot) + AW'(last_now ? col_now : col_inc);
      rd_addr_up2 = slot_base(up2_slot) + AW'(col_now);

      col_in  = col_ff;
      rows_in = rows_ff;
      slot_in = slot_ff;
      if (req_fire) begin
         if (last_now) begin
            col_in  = '0;
            rows_in = (rows_now < 2'd2) ? rows_now + 2'd1 : rows_now;
            slot_in = (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
         end else begin
            col_in  = col_inc;
            rows_in = rows_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         rows_ff <= 2'd0;
         slot_ff <= 2'd0;
      end else begin
         col_ff  <= col_in;
         rows_ff <= rows_in;
         slot_ff <= slot_in;
      end
   end

   // line store
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [VB-1:0] dist_w;
   logic [VB-1:0] rd_up;
   logic [VB-1:0] rd_up2;

   logic          s1_pix_ff;
   logic [IW-1:0] s1_col_ff;
   logic          s1_last_ff;
   logic [1:0]    s1_rows_ff;
   logic [1:0]    s1_slot_ff;

   assign wr_en   = s1_adv;
   assign wr_addr = slot_base(s1_slot_ff) + AW'(s1_col_ff);

   tcbd_ram #(
      .WIDTH (VB),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (dist_w),
      .rd_en     (req_fire),
      .rd_addr_a (rd_addr_up),
      .rd_addr_b (rd_addr_up2),
      .rd_data_a (rd_up),
      .rd_data_b (rd_up2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pix_ff  <= req_chan.pixel;
         s1_col_ff  <= col_now;
         s1_last_ff <= last_now;
         s1_rows_ff <= rows_now;
         s1_slot_ff <= slot_ff;
      end
   end

   // neighbourhood: sliding window on the row above, head of each row kept aside
   logic [VB-1:0] win_a_ff;
   logic [VB-1:0] win_b_ff;
   logic [VB-1:0] head0_ff;
   logic [VB-1:0] head1_ff;
   logic          s1_first;
   logic [VB-1:0] n_left;
   logic [VB-1:0] n_mid;
   logic [VB-1:0] n_right_raw;
   logic [VB-1:0] n_right;
   logic [VB-1:0] m_w;

   always_comb begin
      s1_first    = (s1_col_ff == '0);
      n_left      = s1_first ? '0 : win_a_ff;
      n_mid       = s1_first ? head0_ff : win_b_ff;
      n_right_raw = s1_first ? head1_ff : rd_up;
      n_right     = s1_last_ff ? '0 : n_right_raw;

      m_w = cap_w;
      if (n_left < m_w) m_w = n_left;
      if (n_mid < m_w) m_w = n_mid;
      if (n_right < m_w) m_w = n_right;
      if (rd_up2 < m_w) m_w = rd_up2;

      if (!s1_pix_ff) begin
         dist_w = '0;
      end else if (s1_rows_ff == 2'd2) begin
         dist_w = m_w + VB'(1);
      end else begin
         dist_w = VB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         win_a_ff <= n_mid;
         win_b_ff <= n_right_raw;
         if (s1_first) begin
            head0_ff <= dist_w;
         end
         if (s1_col_ff == IW'(1)) begin
            head1_ff <= dist_w;
         end
      end
   end

   // response register
   logic [tcbd_pkg::DIST_W-1:0] rsp_dist_ff;
   logic                        rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_dist_ff <= tcbd_pkg::DIST_W'(dist_w);
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.distance = rsp_dist_ff;
   assign rsp_chan.row_end  = rsp_last_ff;

   // checks
   a_dist_limit : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> dist_w <= dmax_w)
      else $error("distance above limit");

   a_reset_clear : assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !rsp_valid_ff && col_ff == '0 && rows_ff == 2'd0))
      else $error("pipeline not cleared by reset");

   a_row_codes : assert property (@(posedge clock) disable iff (reset)
      (slot_ff != 2'd3) && (rows_ff != 2'd3))
      else $error("row slot or row count out of range");

endmodule
